// File: rtl/mfb_pkg.sv
// Shared definitions for the monochrome frame store fill engine.
// Holds store geometry, command and register codes, sequencer states and the byte mask helper.
// No dependencies.
package mfb_pkg;

	localparam int MAX_ROW_BYTES = 64;
	localparam int MAX_ROWS      = 512;
	localparam int STORE_DEPTH   = MAX_ROW_BYTES * MAX_ROWS;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int COL_BYTE_W    = $clog2(MAX_ROW_BYTES);
	localparam int BYTE_W        = 8;

	localparam logic [6:0] ROW_BYTES_RST = 7'd16;
	localparam logic [9:0] ROW_COUNT_RST = 10'd128;
	localparam logic [6:0] ROW_BYTES_SAT = 7'(MAX_ROW_BYTES);
	localparam logic [9:0] ROW_COUNT_SAT = 10'(MAX_ROWS);

	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_FILL  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic {
		REG_ROW_BYTES = 1'b0,
		REG_ROW_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SETUP,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// bits for columns lead..7-trail of one byte, MSB first
	function automatic logic [BYTE_W-1:0] byte_mask(input logic [2:0] lead,
			input logic [2:0] trail);
		byte_mask = (8'hFF >> lead) & (8'hFF << trail);
	endfunction

endpackage

// File: rtl/mfb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/mfb_seq.sv
// Command sequencer and byte address unit for the frame store engine.
// Runs the post-reset clearing pass and the read-modify-write loops. Uses mfb_pkg.
module mfb_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                mode,
	input  logic [8:0]                pos_x,
	input  logic [8:0]                pos_y,
	input  logic [9:0]                rect_width,
	input  logic [9:0]                rect_height,
	input  logic                      pixel_value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      read_value,
	output logic                      in_range,
	input  logic [6:0]                rb,
	input  logic [9:0]                rc,
	output mfb_pkg::ram_req_t         ram_req,
	input  logic [mfb_pkg::BYTE_W-1:0] ram_rdata
);

	mfb_pkg::state_t state_q, state_d;

	logic [mfb_pkg::ADDR_W-1:0]     clr_cnt_q;
	mfb_pkg::mode_t                 mode_q;
	logic [8:0]                     px_q;
	logic [8:0]                     py_q;
	logic [9:0]                     rw_q;
	logic [9:0]                     rh_q;
	logic                           val_q;
	logic                           inside_q;
	logic                           rd_q;
	logic [8:0]                     x0_q;
	logic [2:0]                     xl_lo_q;
	logic [9:0]                     y_q;
	logic [9:0]                     y1_q;
	logic [mfb_pkg::COL_BYTE_W-1:0] bfirst_q;
	logic [mfb_pkg::COL_BYTE_W-1:0] blast_q;
	logic [mfb_pkg::COL_BYTE_W-1:0] b_q;
	logic [mfb_pkg::ADDR_W-1:0]     row_base_q;
	logic                           out_valid_q;
	logic                           read_value_q;
	logic                           in_range_q;

	// setup geometry
	logic        is_clear;
	logic        is_pixel;
	logic [9:0]  wpix;
	logic        pix_in_frame;
	logic [8:0]  x0;
	logic [8:0]  y0;
	logic [10:0] x_end_raw;
	logic [10:0] y_end_raw;
	logic [9:0]  x_end;
	logic [9:0]  y_end;
	logic [9:0]  x_last;
	logic        area_ok;
	logic [15:0] prod;

	// loop datapath
	logic [mfb_pkg::ADDR_W-1:0] addr_cur;
	logic [mfb_pkg::ADDR_W-1:0] row_next;
	logic [9:0]                 y_next;
	logic                       row_end;
	logic                       loop_end;
	logic [2:0]                 lead;
	logic [2:0]                 trail;
	logic [mfb_pkg::BYTE_W-1:0] fmask;
	logic [mfb_pkg::BYTE_W-1:0] pbit;
	logic                       accept;
	logic                       out_load;

	assign is_clear     = (mode_q == mfb_pkg::MODE_CLEAR);
	assign is_pixel     = (mode_q == mfb_pkg::MODE_SET) || (mode_q == mfb_pkg::MODE_READ);
	assign wpix         = {rb, 3'b000};
	assign pix_in_frame = ({1'b0, px_q} < wpix) && ({1'b0, py_q} < rc);
	assign x0        = is_clear ? 9'd0 : px_q;
	assign y0        = is_clear ? 9'd0 : py_q;
	assign x_end_raw = is_clear ? {1'b0, wpix} : ({2'b00, px_q} + {1'b0, rw_q});
	assign y_end_raw = is_clear ? {1'b0, rc} : ({2'b00, py_q} + {1'b0, rh_q});
	assign x_end     = (x_end_raw > {1'b0, wpix}) ? wpix : x_end_raw[9:0];
	assign y_end     = (y_end_raw > {1'b0, rc}) ? rc : y_end_raw[9:0];
	assign x_last    = x_end - 10'd1;
	assign area_ok   = ({1'b0, x0} < x_end) && ({1'b0, y0} < y_end);
	assign prod      = y0 * rb;

	assign addr_cur = row_base_q + mfb_pkg::ADDR_W'(b_q);
	assign row_next = row_base_q + mfb_pkg::ADDR_W'(rb);
	assign y_next   = y_q + 10'd1;
	assign row_end  = (b_q == blast_q);
	assign loop_end = row_end && (y_next == y1_q);
	assign lead     = (b_q == bfirst_q) ? x0_q[2:0] : 3'd0;
	assign trail    = row_end ? (3'd7 - xl_lo_q) : 3'd0;
	assign fmask    = mfb_pkg::byte_mask(lead, trail);
	assign pbit     = 8'h80 >> px_q[2:0];

	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == mfb_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mfb_pkg::ST_INIT: begin
				if (&clr_cnt_q) begin
					state_d = mfb_pkg::ST_IDLE;
				end
			end
			mfb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = mfb_pkg::ST_SETUP;
				end
			end
			mfb_pkg::ST_SETUP: begin
				if (is_pixel) begin
					state_d = pix_in_frame ? mfb_pkg::ST_PIX_RD : mfb_pkg::ST_DONE;
				end else begin
					state_d = area_ok ? mfb_pkg::ST_FILL_RD : mfb_pkg::ST_DONE;
				end
			end
			mfb_pkg::ST_PIX_RD:  state_d = mfb_pkg::ST_PIX_WR;
			mfb_pkg::ST_PIX_WR:  state_d = mfb_pkg::ST_DONE;
			mfb_pkg::ST_FILL_RD: state_d = mfb_pkg::ST_FILL_WR;
			mfb_pkg::ST_FILL_WR: begin
				state_d = loop_end ? mfb_pkg::ST_DONE : mfb_pkg::ST_FILL_RD;
			end
			mfb_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = mfb_pkg::ST_IDLE;
				end
			end
			default: state_d = mfb_pkg::ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		in_ready      = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = addr_cur;
		ram_req.wdata = '0;
		ram_req.raddr = addr_cur;
		unique case (state_q)
			mfb_pkg::ST_INIT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_cnt_q;
			end
			mfb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			mfb_pkg::ST_PIX_WR: begin
				ram_req.we    = (mode_q == mfb_pkg::MODE_SET);
				ram_req.wdata = val_q ? (ram_rdata | pbit) : (ram_rdata & ~pbit);
			end
			mfb_pkg::ST_FILL_WR: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = val_q ? (ram_rdata | fmask) : (ram_rdata & ~fmask);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mfb_pkg::ST_INIT;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mfb_pkg::ST_INIT) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mfb_pkg::mode_t'(mode);
			px_q   <= pos_x;
			py_q   <= pos_y;
			rw_q   <= rect_width;
			rh_q   <= rect_height;
			val_q  <= pixel_value;
		end
		case (state_q)
			mfb_pkg::ST_SETUP: begin
				inside_q   <= pix_in_frame;
				rd_q       <= 1'b0;
				x0_q       <= x0;
				xl_lo_q    <= x_last[2:0];
				y_q        <= {1'b0, y0};
				y1_q       <= y_end;
				bfirst_q   <= x0[8:3];
				blast_q    <= x_last[8:3];
				b_q        <= x0[8:3];
				row_base_q <= prod[mfb_pkg::ADDR_W-1:0];
				// clear writes zeros
				if (is_clear) begin
					val_q <= 1'b0;
				end
			end
			mfb_pkg::ST_PIX_WR: begin
				if (mode_q == mfb_pkg::MODE_READ) begin
					rd_q <= ram_rdata[3'd7 - px_q[2:0]];
				end
			end
			mfb_pkg::ST_FILL_WR: begin
				if (row_end) begin
					b_q        <= bfirst_q;
					y_q        <= y_next;
					row_base_q <= row_next;
				end else begin
					b_q <= b_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			read_value_q <= rd_q;
			in_range_q   <= inside_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign in_range   = in_range_q;

endmodule

// File: rtl/mono_framebuffer_rect_fill.sv
// Top level of the 1-bit-per-pixel frame store engine.
// Holds the geometry registers, the byte store RAM and the sequencer. Uses mfb_pkg,
// mfb_ram and mfb_seq.

// Frame store engine for a 1 bpp display buffer, eight pixels per byte, MSB first,
// row-major. Commands: set pixel, read pixel, fill clipped rectangle, clear frame; each
// returns one result. After reset the block runs a clearing pass over all 32768 bytes
// (one byte per cycle) before in_ready first rises; configuration writes are taken
// at any time. The store is a single byte-wide RAM with one read and one write port,
// and every byte is updated as a read-modify-write: set and read go through setup, a
// read state and a write state; an out-of-frame or empty command goes from setup to the
// result; fill or clear reads, then writes, each byte. One command is in flight at a time.
module mono_framebuffer_rect_fill (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [8:0] pos_x,
	input  logic [8:0] pos_y,
	input  logic [9:0] rect_width,
	input  logic [9:0] rect_height,
	input  logic       pixel_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       read_value,
	output logic       in_range,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data
);

	logic [6:0] row_bytes_q;
	logic [9:0] row_count_q;
	logic [6:0] rb;
	logic [9:0] rc;

	mfb_pkg::ram_req_t          ram_req;
	logic [mfb_pkg::BYTE_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= mfb_pkg::ROW_BYTES_RST;
			row_count_q <= mfb_pkg::ROW_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mfb_pkg::reg_idx_t'(cfg_index))
				mfb_pkg::REG_ROW_BYTES: row_bytes_q <= cfg_data[6:0];
				mfb_pkg::REG_ROW_COUNT: row_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// oversized geometry saturates to the store size
	assign rb = (row_bytes_q > mfb_pkg::ROW_BYTES_SAT) ? mfb_pkg::ROW_BYTES_SAT : row_bytes_q;
	assign rc = (row_count_q > mfb_pkg::ROW_COUNT_SAT) ? mfb_pkg::ROW_COUNT_SAT : row_count_q;

	mfb_ram #(
		.WIDTH (mfb_pkg::BYTE_W),
		.DEPTH (mfb_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	mfb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.in_range    (in_range),
		.rb          (rb),
		.rc          (rc),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata)
	);

endmodule
